>>> src/ifc_pkg.sv
// Shared types and constants for the integer/fixed/float word converter.
package ifc_pkg;

   localparam int WORD_WIDTH = 32;
   localparam int FRAC_WIDTH = 5;
   localparam int EXP_WIDTH = 8;
   localparam int MANT_WIDTH = 23;
   localparam int EXP_BIAS = 127;

   localparam logic [WORD_WIDTH-1:0] EXP_FIELD_MASK = 32'h7f80_0000;
   localparam logic [WORD_WIDTH-1:0] MANT_MASK = 32'h007f_ffff;
   localparam logic [WORD_WIDTH-1:0] HIDDEN_BIT = 32'h0080_0000;

   localparam logic [FRAC_WIDTH-1:0] FRAC_RESET = 5'd8;

   typedef enum logic [1:0] {
      OP_INT_TO_FLOAT   = 2'd0,
      OP_FLOAT_TO_INT   = 2'd1,
      OP_FIXED_TO_FLOAT = 2'd2,
      OP_FLOAT_TO_FIXED = 2'd3
   } opcode_type;

endpackage

>>> src/int_float_fixed_converter_unit.sv
// Integer/fixed-point to IEEE single converter and back, truncating.
// rsp_valid rises once the req has passed the input register and then the result register.
// Throughput: one word per cycle unless rsp_ready stalls; the conversion sits between the two.
// Reset: synchronous, active high; clears both stage valids, fraction_bits returns to 8.
// csr_ready is always high; the converter reads the fraction width from its config register.
module int_float_fixed_converter_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_opcode,
   input  logic [ifc_pkg::WORD_WIDTH-1:0]      req_operand_word,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [ifc_pkg::WORD_WIDTH-1:0]      rsp_result_word,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ifc_pkg::FRAC_WIDTH-1:0]      csr_fraction_bits
);

   logic                                 stage_valid_ff;
   ifc_pkg::opcode_type                  stage_opcode_ff;
   logic [ifc_pkg::WORD_WIDTH-1:0]       stage_word_ff;
   logic                                 rsp_valid_ff;
   logic [ifc_pkg::WORD_WIDTH-1:0]       rsp_word_ff;
   logic [ifc_pkg::FRAC_WIDTH-1:0]       frac_bits_ff;
   logic [ifc_pkg::WORD_WIDTH-1:0]       result_in;
   logic                                 out_ready;
   logic                                 stage_ready;

   // Flow control: each stage advances when the one after it can take data
   assign out_ready = !rsp_valid_ff || rsp_ready;
   assign stage_ready = !stage_valid_ff || out_ready;
   assign req_ready = stage_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_result_word = rsp_word_ff;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         frac_bits_ff <= ifc_pkg::FRAC_RESET;
      end else if (csr_valid) begin
         frac_bits_ff <= csr_fraction_bits;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (stage_ready) begin
         stage_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready && req_valid) begin
         stage_opcode_ff <= ifc_pkg::opcode_type'(req_opcode);
         stage_word_ff <= req_operand_word;
      end
   end

   ifc_convert u_convert (
      .opcode        (stage_opcode_ff),
      .operand_word  (stage_word_ff),
      .fraction_bits (frac_bits_ff),
      .result_word   (result_in)
   );

   // Result register: hold while the consumer stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && stage_valid_ff) begin
         rsp_word_ff <= result_in;
      end
   end

endmodule

>>> src/ifc_convert.sv
// Combinational word conversion between two's complement and IEEE single.
module ifc_convert (
   input  ifc_pkg::opcode_type                  opcode,
   input  logic [ifc_pkg::WORD_WIDTH-1:0]       operand_word,
   input  logic [ifc_pkg::FRAC_WIDTH-1:0]       fraction_bits,
   output logic [ifc_pkg::WORD_WIDTH-1:0]       result_word
);

   logic                              sign;
   logic [ifc_pkg::WORD_WIDTH-1:0]    mag;
   logic [4:0]                        lead_pos;
   logic [ifc_pkg::WORD_WIDTH-1:0]    norm;
   logic [ifc_pkg::FRAC_WIDTH-1:0]    lower;
   logic [8:0]                        exp_sum;
   logic [ifc_pkg::WORD_WIDTH-1:0]    single_word;

   logic [ifc_pkg::FRAC_WIDTH-1:0]    raise;
   logic [ifc_pkg::EXP_WIDTH-1:0]     exp_field;
   logic signed [9:0]                 unb_exp;
   logic signed [9:0]                 shift_amt;
   logic [ifc_pkg::WORD_WIDTH-1:0]    sig;
   logic [ifc_pkg::WORD_WIDTH-1:0]    int_mag;
   logic [ifc_pkg::WORD_WIDTH-1:0]    int_word;

   // Integer or fixed to float: find leading one, normalize, bias exponent
   always_comb begin
      sign = operand_word[ifc_pkg::WORD_WIDTH-1];
      mag = sign ? (32'd0 - operand_word) : operand_word;
      lead_pos = 5'd0;
      for (int i = 0; i < ifc_pkg::WORD_WIDTH; i++) begin
         if (mag[i]) begin
            lead_pos = 5'(i);
         end
      end
      norm = mag << (5'd31 - lead_pos);
      lower = (opcode == ifc_pkg::OP_FIXED_TO_FLOAT) ? fraction_bits : '0;
      exp_sum = {4'd0, lead_pos} + 9'(ifc_pkg::EXP_BIAS) - {4'd0, lower};
      if (mag == '0) begin
         single_word = '0;
      end else begin
         single_word = {sign, exp_sum[7:0], norm[30:8]};
      end
   end

   // Float to integer or fixed: shift significand by unbiased exponent
   always_comb begin
      raise = (opcode == ifc_pkg::OP_FLOAT_TO_FIXED) ? fraction_bits : '0;
      exp_field = 8'((operand_word & ifc_pkg::EXP_FIELD_MASK) >> ifc_pkg::MANT_WIDTH);
      unb_exp = $signed({2'b00, exp_field}) - 10'(ifc_pkg::EXP_BIAS)
                + $signed({5'd0, raise});
      sig = (operand_word & ifc_pkg::MANT_MASK) | ifc_pkg::HIDDEN_BIT;
      if (unb_exp >= 10'(ifc_pkg::MANT_WIDTH)) begin
         shift_amt = unb_exp - 10'(ifc_pkg::MANT_WIDTH);
         int_mag = (shift_amt >= 10'sd32) ? '0 : (sig << shift_amt[4:0]);
      end else begin
         shift_amt = 10'(ifc_pkg::MANT_WIDTH) - unb_exp;
         int_mag = (shift_amt >= 10'sd32) ? '0 : (sig >> shift_amt[4:0]);
      end
      int_word = operand_word[ifc_pkg::WORD_WIDTH-1] ? (32'd0 - int_mag) : int_mag;
   end

   // Select direction
   always_comb begin
      unique case (opcode)
         ifc_pkg::OP_INT_TO_FLOAT,
         ifc_pkg::OP_FIXED_TO_FLOAT: begin
            result_word = single_word;
         end
         ifc_pkg::OP_FLOAT_TO_INT,
         ifc_pkg::OP_FLOAT_TO_FIXED: begin
            result_word = int_word;
         end
         default: begin
            result_word = int_word;
         end
      endcase
   end

endmodule
